FILE: src/tqr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tqr_pkg
// Shared types and field widths for the ticket queue with removal by id.
// ---------------------------------------------------------------------------
package tqr_pkg;

   // fixed field widths
   localparam int ID_W       = 16;
   localparam int POS_W      = 5;
   localparam int WAIT_W     = 12;
   localparam int SVC_W      = 8;
   localparam int ACT_W      = 2;

   // saturation limits of the reported position and waits
   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

   // stream widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_TUSER_W = 2;

   // reset value of the service time register
   localparam logic [SVC_W-1:0] SVC_RESET = 8'd1;

   // request kinds
   typedef enum logic [ACT_W-1:0] {
      ACT_JOIN  = 2'd0,
      ACT_LEAVE = 2'd1,
      ACT_QUERY = 2'd2
   } tqr_action_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } tqr_state_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic capture;   // latch compare result for the new item
      logic append;    // load the new ticket
      logic shift;     // close the gap behind the first hit
   } tqr_cell_ctrl_type;

endpackage
`default_nettype wire

FILE: src/tqr_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tqr_cell
// One queue slot: holds a ticket, compares it with the looked-up id and
// takes its neighbor's ticket when the entries behind a removal move up.
// ---------------------------------------------------------------------------
module tqr_cell
   import tqr_pkg::*;
#(
   parameter int TICKET_BITS = 16
) (
   input  wire logic                   clock,
   input  wire tqr_cell_ctrl_type      ctrl,
   input  wire logic                   occupied,
   input  wire logic [TICKET_BITS-1:0] cmp_id,
   input  wire logic [TICKET_BITS-1:0] new_ticket,
   input  wire logic [TICKET_BITS-1:0] next_entry,
   input  wire logic                   hit_in,
   output logic [TICKET_BITS-1:0]      entry,
   output logic                        hit_out,
   output logic                        first
);

   logic [TICKET_BITS-1:0] entry_ff;
   logic [TICKET_BITS-1:0] entry_in;
   logic                   match_ff;
   logic                   match_in;

   // compare only live slots
   always_comb begin
      match_in = match_ff;
      if (ctrl.capture) begin
         match_in = occupied && (entry_ff == cmp_id);
      end
   end

   // hit seen at or ahead of this slot
   assign hit_out = hit_in | match_ff;
   assign first   = match_ff & ~hit_in;

   // slot load: append at the tail or move up behind the hit
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append) begin
         entry_in = new_ticket;
      end else if (ctrl.shift && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

FILE: src/ticket_queue_remove_by_id.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ticket_queue_remove_by_id
// Ordered ticket queue with join, leave by ticket number and position query.
// ---------------------------------------------------------------------------
// In the accept cycle each slot of the cell chain compares its ticket
// with the requested id and latches the result; in the execute state the
// first hit is resolved along the chain, the entries behind a removed
// ticket move up one slot (or a join is written at the tail) and the
// result goes to the output register. An item waits in the execute
// state only while the output register still holds an untaken result.
// The ticket store needs no clearing after reset: only slots below the
// entry count are ever compared. A join into a full queue is refused;
// a leave or query of an absent ticket reports found low and a position
// equal to the count. Unused request kinds change nothing.
// ---------------------------------------------------------------------------
module ticket_queue_remove_by_id
   import tqr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TICKET_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: tuser = action, tdata = ticket_id
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] ticket_id
   input  wire logic [ACT_W-1:0]       req_tuser,   // [1:0] action
   // result
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [15:0] assigned_id, [20:16] position, [32:21] wait_time,
   // [37:33] queue_count, [49:38] total_wait, [55:50] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // [0] accepted, [1] found
   output logic [RSP_TUSER_W-1:0]      rsp_tuser,
   // service time register
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [SVC_W-1:0]       csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = CNT_W + POS_W;
   localparam int MUL_W = SVC_W + CNT_W + 4;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // control state
   tqr_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [TICKET_BITS-1:0] next_ff, next_in;
   logic [SVC_W-1:0]       svc_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // latched request
   logic [ACT_W-1:0]       act_ff;

   // output payload
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic req_take;
   logic exec_go;
   logic join_store;
   logic leave_go;

   // chain signals
   logic [TICKET_BITS-1:0]  entries [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]    hit_chain;
   logic [QUEUE_DEPTH-1:0]  first_vec;
   logic [TICKET_BITS-1:0]  cmp_id;
   logic [ID_W+TICKET_BITS-1:0] id_wide;
   logic [ID_W+TICKET_BITS-1:0] tkt_wide;
   logic                    any_hit;
   logic [CNT_W-1:0]        hit_pos;

   // result arithmetic
   logic [CNT_W-1:0]  pos_raw;
   logic              res_accepted;
   logic              res_found;
   logic [ID_W-1:0]   res_assigned;
   logic [EXT_W-1:0]  pos_ext;
   logic [POS_W-1:0]  pos_sat;
   logic [EXT_W-1:0]  cnt_ext;
   logic [POS_W-1:0]  cnt_sat;
   logic [MUL_W-1:0]  wait_prod;
   logic [MUL_W-1:0]  total_prod;
   logic [WAIT_W-1:0] wait_sat;
   logic [WAIT_W-1:0] total_sat;

   // ticket id resized to the stored ticket width
   assign id_wide  = {{TICKET_BITS{1'b0}}, req_tdata[ID_W-1:0]};
   assign cmp_id   = id_wide[TICKET_BITS-1:0];
   assign tkt_wide = {{ID_W{1'b0}}, next_ff};

   // ------------------------------------------------------------------
   // cell chain
   // ------------------------------------------------------------------
   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tqr_cell_ctrl_type      ctrl;
      logic [TICKET_BITS-1:0] neighbor;
      logic                   occupied;

      assign occupied     = CNT_W'(i) < count_ff;
      assign ctrl.capture = req_take;
      assign ctrl.append  = join_store && (CNT_W'(i) == count_ff);
      assign ctrl.shift   = leave_go;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign neighbor = entries[i];
      end else begin : g_mid
         assign neighbor = entries[i+1];
      end

      tqr_cell #(
         .TICKET_BITS (TICKET_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .cmp_id     (cmp_id),
         .new_ticket (next_ff),
         .next_entry (neighbor),
         .hit_in     (hit_chain[i]),
         .entry      (entries[i]),
         .hit_out    (hit_chain[i+1]),
         .first      (first_vec[i])
      );
   end

   assign any_hit = hit_chain[QUEUE_DEPTH];

   // slot number of the first hit
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_pos = hit_pos | (first_vec[i] ? CNT_W'(i) : '0);
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      exec_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: exec_go = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            exec_go    = 1'b0;
         end
      endcase
   end

   assign req_take = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // request decode and result fields
   // ------------------------------------------------------------------
   always_comb begin
      join_store   = 1'b0;
      leave_go     = 1'b0;
      res_accepted = 1'b0;
      res_found    = 1'b0;
      res_assigned = '0;
      pos_raw      = '0;
      count_in     = count_ff;
      next_in      = next_ff;
      unique case (act_ff)
         ACT_JOIN: begin
            pos_raw = count_ff;
            if (count_ff < DEPTH_CNT) begin
               join_store   = exec_go;
               res_accepted = 1'b1;
               res_assigned = tkt_wide[ID_W-1:0];
               if (exec_go) begin
                  count_in = count_ff + 1'b1;
                  next_in  = next_ff + 1'b1;
               end
            end
         end
         ACT_LEAVE, ACT_QUERY: begin
            pos_raw   = any_hit ? hit_pos : count_ff;
            res_found = any_hit;
            if (act_ff == ACT_LEAVE && any_hit) begin
               leave_go     = exec_go;
               res_accepted = 1'b1;
               if (exec_go) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            pos_raw = '0;
         end
      endcase
   end

   // saturate positions and waits
   assign pos_ext    = EXT_W'(pos_raw);
   assign pos_sat    = (pos_ext > EXT_W'(POS_MAX)) ? POS_MAX : pos_ext[POS_W-1:0];
   assign wait_prod  = MUL_W'(svc_ff) * MUL_W'(pos_raw);
   assign wait_sat   = (wait_prod > MUL_W'(WAIT_MAX)) ? WAIT_MAX : wait_prod[WAIT_W-1:0];

   assign cnt_ext    = EXT_W'(count_in);
   assign cnt_sat    = (cnt_ext > EXT_W'(POS_MAX)) ? POS_MAX : cnt_ext[POS_W-1:0];
   assign total_prod = MUL_W'(svc_ff) * MUL_W'(count_in);
   assign total_sat  = (total_prod > MUL_W'(WAIT_MAX)) ? WAIT_MAX : total_prod[WAIT_W-1:0];

   // output register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, total_sat, cnt_sat, wait_sat, pos_sat, res_assigned};
         rsp_user_in  = {res_found, res_accepted};
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_ff      <= '0;
         svc_ff       <= SVC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            svc_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (req_take) begin
         act_ff <= req_tuser;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond queue depth");

   // compare results are only defined once an item has been captured
   a_single_first: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> $onehot0(first_vec))
      else $error("more than one first hit in the chain");

   a_join_grows: assert property (@(posedge clock) disable iff (reset)
      join_store |=> count_ff == $past(count_ff) + 1'b1)
      else $error("stored join did not grow the queue");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_EXEC)
      else $error("result appeared without an executed item");

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stream-level test of the ticket queue with removal by ticket number.
// A queue of pending items feeds a clocked driver that sends in bursts with
// random gaps, while the result side stalls on a changing pattern. Every
// accepted item runs through a local model of the queue, and each result
// is compared field by field with the oldest prediction. The run covers a
// directed opening and random traffic under several service time settings.
// ---------------------------------------------------------------------------
module tb_top;
   import tqr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 16;
   localparam int LIMIT     = 200_000;
   localparam int CHUNK     = 110;
   localparam int MAX_SHOWN = 50;

   // code with no operation behind it
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [ID_W-1:0]  ticket_id;
   } ticket_req_type;

   typedef struct packed {
      logic              accepted;
      logic              found;
      logic [ID_W-1:0]   assigned_id;
      logic [POS_W-1:0]  position;
      logic [WAIT_W-1:0] wait_time;
      logic [POS_W-1:0]  queue_count;
      logic [WAIT_W-1:0] total_wait;
   } ticket_rsp_type;

   typedef struct packed {
      logic [DEPTH-1:0][ID_W-1:0] slots;
      logic [POS_W-1:0]           count;
      logic [ID_W-1:0]            next_id;
      logic [SVC_W-1:0]           svc_time;
   } queue_state_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [SVC_W-1:0]       csr_data = '0;

   ticket_req_type  pending_req[$];
   ticket_rsp_type  expected_rsp[$];
   queue_state_type gen_state;
   queue_state_type chk_state;

   bit  req_taken = 1'b0;
   int  mismatches = 0;
   int  rsp_seen = 0;
   int  cycle_count = 0;
   int  burst_left = 4;
   int  gap_left = 0;
   int  stall_idx = 0;
   logic [15:0] stall_pat = '1;

   ticket_queue_remove_by_id #(
      .QUEUE_DEPTH (DEPTH),
      .TICKET_BITS (ID_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // position and waits saturate at their field limits
   function automatic logic [POS_W-1:0] clip_pos(input int p);
      return (p > 31) ? POS_MAX : p[POS_W-1:0];
   endfunction

   function automatic logic [WAIT_W-1:0] wait_for(input logic [SVC_W-1:0] svc, input int p);
      int w;
      w = int'(svc) * p;
      return (w > 4095) ? WAIT_MAX : w[WAIT_W-1:0];
   endfunction

   // one item applied to a queue state; returns the result it yields
   function automatic ticket_rsp_type queue_apply(inout queue_state_type q,
                                                  input ticket_req_type r);
      ticket_rsp_type o;
      int             hit;
      o   = '0;
      hit = int'(q.count);
      if (r.action == ACT_JOIN) begin
         if (q.count < DEPTH) begin
            q.slots[q.count] = q.next_id;
            o.assigned_id    = q.next_id;
            q.next_id        = q.next_id + 1'b1;
            q.count          = q.count + 1'b1;
            o.accepted       = 1'b1;
         end
      end else if (r.action == ACT_LEAVE || r.action == ACT_QUERY) begin
         // the match nearest the head wins
         for (int i = DEPTH - 1; i >= 0; i--)
            if (i < q.count && q.slots[i] == r.ticket_id) hit = i;
         if (hit < q.count) begin
            o.found = 1'b1;
            if (r.action == ACT_LEAVE) begin
               for (int i = 0; i < DEPTH - 1; i++)
                  if (i >= hit) q.slots[i] = q.slots[i+1];
               q.count    = q.count - 1'b1;
               o.accepted = 1'b1;
            end
         end
      end
      if (r.action != ACT_UNUSED) begin
         o.position  = clip_pos(hit);
         o.wait_time = wait_for(q.svc_time, hit);
      end
      o.queue_count = clip_pos(int'(q.count));
      o.total_wait  = wait_for(q.svc_time, int'(q.count));
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int exp_v);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                  rsp_seen, what, got_v, exp_v);
   endtask

   // queue one item for the driver, tracking the contents for id choice
   task automatic push_item(input logic [ACT_W-1:0] action, input logic [ID_W-1:0] id);
      ticket_req_type r;
      r.action    = action;
      r.ticket_id = id;
      void'(queue_apply(gen_state, r));
      pending_req = {pending_req, r};
   endtask

   // mostly joins and lookups of tickets that are present, some noise
   task automatic push_random(input int n, input int join_pct);
      int               roll;
      logic [ACT_W-1:0] act;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         act  = ($urandom_range(0, 1) == 0) ? ACT_LEAVE : ACT_QUERY;
         if (roll < join_pct)
            push_item(ACT_JOIN, ID_W'($urandom));
         else if (roll < 90 && gen_state.count > 0)
            push_item(act, gen_state.slots[$urandom_range(0, gen_state.count - 1)]);
         else if (roll < 96)
            push_item(act, ID_W'($urandom));
         else
            push_item(ACT_UNUSED, ID_W'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_service_time(input logic [SVC_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gen_state.svc_time = value;
      chk_state.svc_time = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver: holds an item until taken, bursts and gaps otherwise
   always @(negedge clock) begin
      logic hold;
      logic drive;
      hold  = req_tvalid;
      drive = 1'b0;
      if (req_taken) begin
         void'(pending_req.pop_front());
         req_taken = 1'b0;
         hold      = 1'b0;
      end
      if (reset) begin
         drive = 1'b0;
      end else if (hold) begin
         drive = 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
      end else if (pending_req.size() != 0) begin
         drive = 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
         end
      end
      req_tvalid <= drive;
      if (drive) begin
         req_tuser <= pending_req[0].action;
         req_tdata <= pending_req[0].ticket_id;
      end
   end

   // result side stall pattern, reshuffled whenever its 16-entry index wraps
   always @(negedge clock) begin
      stall_idx = (stall_idx + 1) % 16;
      if (stall_idx == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               stall_pat = '1;
            end
            1: begin
               stall_pat = 16'($urandom & $urandom);
            end
            default: begin
               stall_pat = 16'($urandom);
            end
         endcase
      end
      rsp_tready <= stall_pat[stall_idx];
   end

   // monitor: predict on every accepted item, check every accepted result
   always @(posedge clock) begin
      ticket_req_type r;
      ticket_rsp_type got;
      ticket_rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r.action     = req_tuser;
            r.ticket_id  = req_tdata;
            want         = queue_apply(chk_state, r);
            expected_rsp = {expected_rsp, want};
            req_taken    = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.accepted    = rsp_tuser[0];
            got.found       = rsp_tuser[1];
            got.assigned_id = rsp_tdata[15:0];
            got.position    = rsp_tdata[20:16];
            got.wait_time   = rsp_tdata[32:21];
            got.queue_count = rsp_tdata[37:33];
            got.total_wait  = rsp_tdata[49:38];
            if (expected_rsp.size() == 0) begin
               report_mismatch("result with nothing expected", int'(rsp_tdata[31:0]), 0);
            end else begin
               want = expected_rsp.pop_front();
               if (got.accepted !== want.accepted)
                  report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
               if (got.found !== want.found)
                  report_mismatch("found", int'(got.found), int'(want.found));
               if (got.assigned_id !== want.assigned_id)
                  report_mismatch("assigned_id", int'(got.assigned_id),
                                  int'(want.assigned_id));
               if (got.position !== want.position)
                  report_mismatch("position", int'(got.position), int'(want.position));
               if (got.wait_time !== want.wait_time)
                  report_mismatch("wait_time", int'(got.wait_time), int'(want.wait_time));
               if (got.queue_count !== want.queue_count)
                  report_mismatch("queue_count", int'(got.queue_count),
                                  int'(want.queue_count));
               if (got.total_wait !== want.total_wait)
                  report_mismatch("total_wait", int'(got.total_wait),
                                  int'(want.total_wait));
            end
            rsp_seen++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      gen_state          = '0;
      gen_state.svc_time = SVC_RESET;
      chk_state          = gen_state;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty queue, fill to full, refused join, hits at both ends
      push_item(ACT_QUERY, 16'h0000);
      push_item(ACT_LEAVE, 16'hFFFF);
      push_item(ACT_UNUSED, 16'hFFFF);
      for (int k = 0; k < DEPTH; k++)
         push_item(ACT_JOIN, (k % 2 == 0) ? 16'h0000 : 16'hFFFF);
      push_item(ACT_JOIN, 16'hA5A5);
      push_item(ACT_QUERY, 16'd15);
      push_item(ACT_QUERY, 16'd0);
      push_item(ACT_QUERY, 16'hFFFF);
      push_item(ACT_LEAVE, 16'd7);
      push_item(ACT_LEAVE, 16'd0);
      push_item(ACT_LEAVE, 16'd15);
      push_item(ACT_QUERY, 16'd7);
      push_item(ACT_UNUSED, 16'h0000);

      set_service_time(8'd255);
      push_random(CHUNK, 45);

      set_service_time(8'd0);
      push_random(CHUNK, 60);
      // sender holds off until every result is back
      wait_drained();
      push_random(CHUNK, 30);

      set_service_time(SVC_W'($urandom_range(0, 255)));
      push_random(CHUNK, 50);

      set_service_time(8'd1);
      push_random(CHUNK, 40);

      wait_drained();
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("results never arrived", expected_rsp.size(), 0);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
